[design/extent_bitmap_overlap_marker_top_assert.svh]
// Assertion macros shared by the checker of the overlap marker.
`ifndef EXTENT_BITMAP_OVERLAP_MARKER_TOP_ASSERT_SVH
`define EXTENT_BITMAP_OVERLAP_MARKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define EBOM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EBOM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ebom_pkg.sv]
package ebom_pkg;

  // Default sizes of the bitmap.
  localparam int EBOM_NUM_BLOCKS = 65536;
  localparam int EBOM_WORD_BITS  = 32;

  // Fixed field widths.
  localparam int BLK_W     = 16;
  localparam int LEN_W     = 16;
  localparam int CNT_W     = 16;

  // Function codes of an input word.
  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // One input word.
  typedef struct packed {
    logic             func;
    logic [BLK_W-1:0] extent_begin;
    logic [LEN_W-1:0] extent_length;
    logic             last_extent;
  } ebom_item_t;

  // One result word.
  typedef struct packed {
    logic             overlap_here;
    logic [CNT_W-1:0] overlap_blocks;
    logic             group_overlap;
    logic             out_of_range;
  } ebom_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_fin;
    logic clr_step;
    logic rd;
    logic wr;
    logic finish;
  } ebom_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_empty;
    logic clr_done;
    logic walk_done;
    logic clear_item;
    logic out_busy;
  } ebom_sts_t;

endpackage

[design/ebom_ram.sv]
module ebom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ebom_ctrl.sv]
module ebom_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_func,
  input  ebom_pkg::ebom_sts_t sts,
  output ebom_pkg::ebom_cmd_t cmd,
  output logic                item_stall
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands for the current step.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = sts.clear_item ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = (item_func == ebom_pkg::FUNC_CLEAR) ? S_CLEAR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_fin = 1'b1;
        state_next  = sts.div_empty ? S_DONE : S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = sts.walk_done ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register; the input side is open only in the idle state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      item_stall <= 1'b1;
    end else begin
      state      <= state_next;
      item_stall <= (state_next != S_IDLE);
    end
  end

endmodule

[design/ebom_datapath.sv]
module ebom_datapath #(
  parameter int NUM_BLOCKS = ebom_pkg::EBOM_NUM_BLOCKS,
  parameter int WORD_BITS  = ebom_pkg::EBOM_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ebom_pkg::ebom_cmd_t    cmd,
  output ebom_pkg::ebom_sts_t    sts,
  input  ebom_pkg::ebom_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ebom_pkg::ebom_result_t result
);

  localparam int BLK_W     = ebom_pkg::BLK_W;
  localparam int LEN_W     = ebom_pkg::LEN_W;
  localparam int CNT_W     = ebom_pkg::CNT_W;
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int NB_W      = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W     = (NB_W > BLK_W + 1) ? NB_W : BLK_W + 1;
  localparam int POP_W     = $clog2(WORD_BITS + 1);
  localparam int NGRP      = (WORD_BITS + 7) / 8;
  localparam int RCP_SH    = BLK_W + OFF_W;
  localparam int RCP_W     = BLK_W + 1;
  localparam int PROD_W    = BLK_W + RCP_W;
  localparam logic [PROD_W-1:0] RCP =
    PROD_W'(((64'd1 << RCP_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  // Control registers.
  logic              clear_q;
  logic              grp_flag;
  logic [ADDR_W-1:0] addr;

  // Payload registers.
  logic              last_q;
  logic              oor_q;
  logic [BLK_W-1:0]  beg_q;
  logic [OFF_W-1:0]  off;
  logic [LEN_W-1:0]  remaining;
  logic [CNT_W-1:0]  count;

  // Extent clipping at load.
  logic [CMP_W-1:0] beg_ext;
  logic [CMP_W-1:0] end_ext;
  logic [CMP_W-1:0] stop_ext;
  logic [CMP_W-1:0] span;
  logic             oor;

  always_comb begin
    beg_ext  = CMP_W'(item.extent_begin);
    end_ext  = CMP_W'(item.extent_begin) + CMP_W'(item.extent_length);
    oor      = end_ext > CMP_W'(NUM_BLOCKS);
    stop_ext = oor ? CMP_W'(NUM_BLOCKS) : end_ext;
    span     = (stop_ext > beg_ext) ? (stop_ext - beg_ext) : '0;
  end

  // First word and bit offset of the extent, by reciprocal multiplication.
  logic [PROD_W-1:0] prod;
  logic [BLK_W-1:0]  quot;
  logic [BLK_W-1:0]  base;
  logic [OFF_W-1:0]  first_off;

  always_comb begin
    prod      = PROD_W'(beg_q) * RCP;
    quot      = BLK_W'(prod >> RCP_SH);
    base      = quot * BLK_W'(WORD_BITS);
    first_off = OFF_W'(beg_q - base);
  end

  // Mask of the extent's blocks inside the current word.
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] mask;
  logic [OFF_W:0]       room;
  logic [OFF_W:0]       take;
  logic [OFF_W:0]       hi;

  always_comb begin
    room = (OFF_W+1)'(WORD_BITS) - {1'b0, off};
    take = (remaining < LEN_W'(room)) ? (OFF_W+1)'(remaining) : room;
    hi   = {1'b0, off} + take;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ((OFF_W+1)'(b) >= {1'b0, off}) && ((OFF_W+1)'(b) < hi);
    end
  end

  // Population count of the blocks already owned, in byte groups.
  logic [NGRP*8-1:0] hits;
  logic [3:0]        grp_cnt [NGRP];
  logic [POP_W-1:0]  pop;

  always_comb begin
    hits = (NGRP*8)'(rdata & mask);
    for (int g = 0; g < NGRP; g++) begin
      grp_cnt[g] = '0;
      for (int k = 0; k < 8; k++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(hits[g*8+k]);
      end
    end
    pop = '0;
    for (int g = 0; g < NGRP; g++) begin
      pop = pop + POP_W'(grp_cnt[g]);
    end
  end

  // Bitmap memory; the clear sweep writes zeros.
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;

  assign ram_we    = cmd.clr_step | cmd.wr;
  assign ram_wdata = cmd.clr_step ? '0 : (rdata | mask);

  ebom_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // Status to the controller.
  logic here;
  logic grp;

  assign here           = count != '0;
  assign grp            = grp_flag | here;
  assign sts.div_empty  = remaining == '0;
  assign sts.clr_done   = addr == ADDR_W'(MAP_WORDS - 1);
  assign sts.walk_done  = remaining == LEN_W'(take);
  assign sts.clear_item = clear_q;
  assign sts.out_busy   = result_valid & result_stall;

  // Control registers: word address, clear mark, group flag, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr         <= '0;
      clear_q      <= 1'b0;
      grp_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr    <= '0;
        clear_q <= (item.func == ebom_pkg::FUNC_CLEAR);
      end else if (cmd.div_fin) begin
        addr <= ADDR_W'(quot);
      end else if (cmd.clr_step || cmd.wr) begin
        addr <= addr + ADDR_W'(1);
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
        clear_q      <= 1'b0;
        if (!clear_q) begin
          grp_flag <= last_q ? 1'b0 : grp;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the walk and the result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_q    <= item.last_extent;
      oor_q     <= oor;
      remaining <= LEN_W'(span);
      beg_q     <= item.extent_begin;
      count     <= '0;
    end
    if (cmd.div_fin) begin
      off <= first_off;
    end
    if (cmd.wr) begin
      count     <= count + CNT_W'(pop);
      remaining <= remaining - LEN_W'(take);
      off       <= '0;
    end
    if (cmd.finish) begin
      if (clear_q) begin
        result <= '0;
      end else begin
        result.overlap_here   <= here;
        result.overlap_blocks <= count;
        result.group_overlap  <= grp;
        result.out_of_range   <= oor_q;
      end
    end
  end

endmodule

[design/extent_bitmap_overlap_marker_top.sv]
// Block-ownership bitmap with overlap check. A mark word brings an extent
// (first block, length); the block counts how many of its blocks were
// already owned, then sets them all, and returns one result word with the
// overlap flag, the overlap count, the sticky group flag (cleared after the
// word marked last of its group) and a flag for extents clipped at the
// bitmap end. A clear word zeroes the bitmap and returns an all-zero result.
// The bitmap sits in one RAM of ceil(NUM_BLOCKS / WORD_BITS) words, walked
// one word per read-modify-write, a read state then a write state. For a
// mark word a lookup state first finds the first word and bit offset by a
// reciprocal multiplication; the walk then covers each bitmap word that
// the clipped extent touches, and an empty extent skips it. A done state
// hands the result to the output register, and the next word is taken in
// the idle state that follows. After reset and for each clear word a
// clearing pass writes zeros to the RAM, one word per cycle, during which
// no word is accepted; a clear word then passes through the done state.
// A finished result waits in an output register, so the next word is
// accepted while it is still stalled; that word's result then waits in
// the done state until the output register is free.
module extent_bitmap_overlap_marker_top #(
  parameter int NUM_BLOCKS = ebom_pkg::EBOM_NUM_BLOCKS,
  parameter int WORD_BITS  = ebom_pkg::EBOM_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  ebom_pkg::ebom_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ebom_pkg::ebom_result_t result
);

  ebom_pkg::ebom_cmd_t cmd;
  ebom_pkg::ebom_sts_t sts;

  // Sequencer of the clear sweep, the word lookup and the word walk.
  ebom_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_func  (item.func),
    .sts        (sts),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // Bitmap memory, word lookup, mask and count logic, result register.
  ebom_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[design/ebom_checker.sv]
`include "extent_bitmap_overlap_marker_top_assert.svh"

module ebom_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input ebom_pkg::ebom_result_t result
);

  // A stalled result word holds.
  `EBOM_ASSERT_NXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // The overlap flag agrees with the overlap count.
  `EBOM_ASSERT_IMP(a_here_count, clk, rst, result_valid, result.overlap_here == (result.overlap_blocks != '0), "overlap flag and count disagree")

  // An overlap in this extent always shows in the group flag.
  `EBOM_ASSERT_IMP(a_group_sticky, clk, rst, result_valid && result.overlap_here, result.group_overlap, "group flag misses an overlap")

  // One word at a time: the input closes right after a word is taken.
  `EBOM_ASSERT_NXT(a_one_at_a_time, clk, rst, item_valid && !item_stall, item_stall, "input open right after a word")

endmodule

bind extent_bitmap_overlap_marker_top ebom_checker u_ebom_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
